// ===== rtl/prc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, codes and helpers of the packet rule classifier.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int PRC_MAX_RULES = 64;

    // command codes (tuser)
    localparam logic [1:0] FUNC_CLASSIFY = 2'd0;
    localparam logic [1:0] FUNC_ADD      = 2'd1;
    localparam logic [1:0] FUNC_DELETE   = 2'd2;
    localparam logic [1:0] FUNC_FLUSH    = 2'd3;

    localparam logic [1:0] DIR_ANY       = 2'd2;
    localparam logic [1:0] PROTO_ANY     = 2'd0;
    localparam logic [1:0] CLASS_TCP     = 2'd1;
    localparam logic [1:0] CLASS_UDP     = 2'd2;
    localparam logic [1:0] CODE_INVALID  = 2'd3;

    localparam logic [7:0] IP_NUM_TCP    = 8'd6;
    localparam logic [7:0] IP_NUM_UDP    = 8'd17;

    localparam logic [1:0] VERDICT_DEFAULT = 2'd0;
    localparam logic [1:0] VERDICT_LOG     = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  dir;
        logic [1:0]  pcls;
        logic [1:0]  rproto;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] rnum;
        logic [1:0]  ract;
        logic        bad;
    } t_cmd;

    typedef struct packed {
        logic [15:0] num;
        logic [1:0]  act;
        logic [1:0]  dir;
        logic [1:0]  proto;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_rule;

    typedef struct packed {
        logic [15:0] assigned;
        logic [2:0]  status;
        logic [15:0] mnum;
        logic        matched;
        logic [1:0]  verdict;
    } t_res;

    function automatic logic [1:0] pkt_class(input logic [7:0] ipp);
        logic [1:0] c;
        c = PROTO_ANY;
        if (ipp == IP_NUM_TCP) c = CLASS_TCP;
        else if (ipp == IP_NUM_UDP) c = CLASS_UDP;
        return c;
    endfunction

endpackage

// ===== rtl/prc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_front
// Decodes an incoming transfer into a table command: packet class,
// port masking for non tcp/udp classify packets and add field validity.
// ----------------------------------------------------------------------------
module prc_front (
    input  logic [127:0]        i_tdata,
    input  logic [1:0]          i_tuser,
    output prc_pkg::t_cmd       o_cmd
);
    import prc_pkg::*;

    logic [1:0] w_dir;
    logic [1:0] w_rproto;
    logic [1:0] w_ract;
    logic [1:0] w_pcls;
    logic       w_strip;

    assign w_dir    = i_tdata[1:0];
    assign w_rproto = i_tdata[11:10];
    assign w_ract   = i_tdata[125:124];
    assign w_pcls   = pkt_class(i_tdata[9:2]);
    // other protocols carry no ports when classified
    assign w_strip  = (i_tuser == FUNC_CLASSIFY) && (w_pcls == PROTO_ANY);

    always_comb begin
        o_cmd.func   = i_tuser;
        o_cmd.dir    = w_dir;
        o_cmd.pcls   = w_pcls;
        o_cmd.rproto = w_rproto;
        o_cmd.sip    = i_tdata[43:12];
        o_cmd.dip    = i_tdata[75:44];
        o_cmd.sport  = w_strip ? 16'd0 : i_tdata[91:76];
        o_cmd.dport  = w_strip ? 16'd0 : i_tdata[107:92];
        o_cmd.rnum   = i_tdata[123:108];
        o_cmd.ract   = w_ract;
        o_cmd.bad    = (w_ract == CODE_INVALID) || (w_dir == CODE_INVALID) ||
                       (w_rproto == CODE_INVALID);
    end
endmodule

// ===== rtl/prc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_queue
// Two-entry command queue between the decode front and the table engine.
// ----------------------------------------------------------------------------
module prc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  prc_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output prc_pkg::t_cmd o_data
);
    import prc_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== rtl/prc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_engine
// Rule table engine: sorted rule memory, first-match scan, insert and
// delete by shifting entries, flush, and the result register.
// ----------------------------------------------------------------------------
module prc_engine #(
    parameter int MAX_RULES = prc_pkg::PRC_MAX_RULES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  prc_pkg::t_cmd i_q_data,
    output logic          o_q_pop,
    output logic          o_res_valid,
    output prc_pkg::t_res o_res,
    input  logic          i_res_ready
);
    import prc_pkg::*;

    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CL_RD  = 4'd1;
    localparam logic [3:0] S_CL_EV  = 4'd2;
    localparam logic [3:0] S_AM_RD  = 4'd3;
    localparam logic [3:0] S_AM_EV  = 4'd4;
    localparam logic [3:0] S_SC_RD  = 4'd5;
    localparam logic [3:0] S_SC_EV  = 4'd6;
    localparam logic [3:0] S_AD_CHK = 4'd7;
    localparam logic [3:0] S_AD_SH  = 4'd8;
    localparam logic [3:0] S_AD_WR  = 4'd9;
    localparam logic [3:0] S_DL_SH  = 4'd10;
    localparam logic [3:0] S_DL_WR  = 4'd11;

    t_rule          r_mem [MAX_RULES];
    t_rule          r_rd;
    logic [3:0]     r_state,   n_state;
    logic [CW-1:0]  r_idx,     n_idx;
    logic [CW-1:0]  r_pos,     n_pos;
    logic [CW-1:0]  r_count,   n_count;
    logic [15:0]    r_num,     n_num;
    t_cmd           r_cmd,     n_cmd;
    logic           r_out_valid, n_out_valid;
    t_res           r_out,     n_out;

    logic [CW-1:0]  w_raddr;
    logic           w_we;
    logic [CW-1:0]  w_waddr;
    t_rule          w_wdata;
    logic           w_hit;
    t_rule          w_new;
    logic [CW-1:0]  w_idx_inc;
    logic [CW-1:0]  w_idx_dec;

    assign w_idx_inc = r_idx + CW'(1);
    assign w_idx_dec = r_idx - CW'(1);

    always_comb begin
        w_hit = ((r_rd.dir == DIR_ANY) || (r_rd.dir == r_cmd.dir)) &&
                ((r_rd.proto == PROTO_ANY) || (r_rd.proto == r_cmd.pcls)) &&
                ((r_rd.sip == 32'd0) || (r_rd.sip == r_cmd.sip)) &&
                ((r_rd.dip == 32'd0) || (r_rd.dip == r_cmd.dip)) &&
                ((r_rd.sport == 16'd0) || (r_rd.sport == r_cmd.sport)) &&
                ((r_rd.dport == 16'd0) || (r_rd.dport == r_cmd.dport));
        w_new.num   = r_num;
        w_new.act   = r_cmd.ract;
        w_new.dir   = r_cmd.dir;
        w_new.proto = r_cmd.rproto;
        w_new.sip   = r_cmd.sip;
        w_new.dip   = r_cmd.dip;
        w_new.sport = r_cmd.sport;
        w_new.dport = r_cmd.dport;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr[AW-1:0]] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr[AW-1:0]];
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_count     = r_count;
        n_num       = r_num;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_raddr     = r_idx;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = r_rd;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_data;
                    n_out   = '0;
                    n_idx   = '0;
                    n_num   = i_q_data.rnum;
                    unique case (i_q_data.func)
                        FUNC_CLASSIFY: begin
                            if (r_count == '0) n_out_valid = 1'b1;
                            else               n_state = S_CL_RD;
                        end
                        FUNC_ADD: begin
                            if (i_q_data.bad) begin
                                n_out.status = ST_INVALID;
                                n_out_valid  = 1'b1;
                            end else if (i_q_data.rnum != 16'd0) begin
                                n_state = S_SC_RD;
                            end else if (r_count == '0) begin
                                n_num   = 16'd1;
                                n_state = S_SC_RD;
                            end else begin
                                n_idx   = r_count - CW'(1);
                                n_state = S_AM_RD;
                            end
                        end
                        FUNC_DELETE: begin
                            if (i_q_data.rnum == 16'd0) begin
                                n_out.status = ST_NOT_FOUND;
                                n_out_valid  = 1'b1;
                            end else begin
                                n_state = S_SC_RD;
                            end
                        end
                        default: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_CL_RD: n_state = S_CL_EV;
            S_CL_EV: begin
                if (w_hit) begin
                    n_out.matched = 1'b1;
                    n_out.mnum    = r_rd.num;
                    n_out.verdict = (r_rd.act == CODE_INVALID) ? VERDICT_LOG
                                                               : r_rd.act + 2'd1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end else if (w_idx_inc == r_count) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = S_CL_RD;
                end
            end
            S_AM_RD: n_state = S_AM_EV;
            S_AM_EV: begin
                if (r_rd.num == 16'hFFFF) begin
                    n_out.status = ST_INVALID;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_num   = r_rd.num + 16'd1;
                    n_idx   = '0;
                    n_state = S_SC_RD;
                end
            end
            S_SC_RD: begin
                if (r_idx == r_count) begin
                    if (r_cmd.func == FUNC_ADD) begin
                        n_pos   = r_count;
                        n_state = S_AD_CHK;
                    end else begin
                        n_out.status = ST_NOT_FOUND;
                        n_out_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_state = S_SC_EV;
                end
            end
            S_SC_EV: begin
                if (r_rd.num == r_num) begin
                    if (r_cmd.func == FUNC_ADD) begin
                        n_out.status = ST_EXISTS;
                        n_out_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_DL_SH;
                    end
                end else if (r_rd.num > r_num) begin
                    if (r_cmd.func == FUNC_ADD) begin
                        n_pos   = r_idx;
                        n_state = S_AD_CHK;
                    end else begin
                        n_out.status = ST_NOT_FOUND;
                        n_out_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = S_SC_RD;
                end
            end
            S_AD_CHK: begin
                if (r_count >= CW'(MAX_RULES)) begin
                    n_out.status = ST_FULL;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_idx   = r_count;
                    n_state = S_AD_SH;
                end
            end
            S_AD_SH: begin
                if (r_idx == r_pos) begin
                    w_we           = 1'b1;
                    w_wdata        = w_new;
                    n_count        = r_count + CW'(1);
                    n_out.assigned = r_num;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    w_raddr = w_idx_dec;
                    n_state = S_AD_WR;
                end
            end
            S_AD_WR: begin
                // move entry up by one slot
                w_we    = 1'b1;
                n_idx   = w_idx_dec;
                n_state = S_AD_SH;
            end
            S_DL_SH: begin
                if (w_idx_inc == r_count) begin
                    n_count     = r_count - CW'(1);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    w_raddr = w_idx_inc;
                    n_state = S_DL_WR;
                end
            end
            S_DL_WR: begin
                w_we    = 1'b1;
                n_idx   = w_idx_inc;
                n_state = S_DL_SH;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_num <= n_num;
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RULES))
        else $error("rule count above table size");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (!r_out_valid && r_state == S_IDLE))
        else $error("command taken while a result is pending");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1) ||
             r_count == $past(r_count) - CW'(1) || r_count == '0))
        else $error("rule count jumped");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending while engine busy");
endmodule

// ===== rtl/packet_rule_classifier_core.sv =====
`timescale 1ns / 1ps
// flush and rejected items give their result straight from the idle state;
// classify reads and compares rules in order up to the first match (all on a miss);
// add/delete compare rules in order and shift entries, with an extra read of the last
// rule for an automatic number; a result must be taken before the next item
// starts, so items run one at a time
// a two-entry queue takes transfers meanwhile; reset (synchronous, active low) empties the table
// ----------------------------------------------------------------------------
// packet_rule_classifier_core
// First-match five-tuple rule classifier with add, delete and flush.
// ----------------------------------------------------------------------------
module packet_rule_classifier_core #(
    parameter int MAX_RULES = prc_pkg::PRC_MAX_RULES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // direction, ip_protocol, rule_proto, src_ip, dst_ip, src_port,
    // dst_port, rule_number, rule_action, zero pad
    input  logic [127:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // verdict, matched, match_number, status, assigned_number, zero pad
    output logic [39:0]  m_axis_tdata
);
    import prc_pkg::*;

    t_cmd w_cmd;
    t_cmd w_q_data;
    t_res w_res;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    logic w_push;

    assign s_axis_tready = i_rst_n && !w_full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    prc_front u_front (
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_cmd   (w_cmd)
    );

    prc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    prc_engine #(
        .MAX_RULES (MAX_RULES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, w_res};
endmodule
